### sv/cop_pkg.sv
// Shared types and constants for the conic orbit position core.
// Holds the CORDIC arctangent table and fixed datapath widths.
// No dependencies.
package cop_pkg;

    localparam int unsigned ATAN_LEN  = 24;
    localparam int unsigned QUOT_BITS = 49;   // numerator width, also quotient width
    localparam int unsigned ROT_BITS  = 34;   // CORDIC x, y, z width (Q2.30 plus guard)
    localparam int unsigned ACC_BITS  = 85;   // product accumulator r * c
    localparam int unsigned POS_BITS  = 21;

    localparam logic [31:0] CORDIC_X0 = 32'd652032874;

    localparam logic [2:0] REG_SEMI_MAJOR = 3'd0;
    localparam logic [2:0] REG_ECC        = 3'd1;
    localparam logic [2:0] REG_ANG_SPEED  = 3'd2;
    localparam logic [2:0] REG_CENTER_X   = 3'd3;
    localparam logic [2:0] REG_CENTER_Y   = 3'd4;
    localparam logic [2:0] REG_ENABLE     = 3'd5;
    localparam logic [2:0] REG_START_PH   = 3'd6;

    typedef logic [31:0] atan_t;

    function automatic atan_t atan_turns(input logic [4:0] idx);
        atan_t v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/conic_orbit_position_core.sv
// Conic orbit position core: phase step, CORDIC sin/cos, conic radius, position.
// Depends on cop_pkg (arctangent table, widths, register indexes).
// Sequence per accepted beat: phase step, CORDIC iterations, quadrant fix, e * c,
// denominator, bit-serial divider and bit-serial radius multiplier over the 49-bit
// radius, then output register. One item at a time: no new beat is accepted until
// the result is loaded, and a stalled output holds the core in its output state.
// Disabled items are dropped in the accept cycle. Reset (sync, active low)
// restores register defaults, zeroes the phase and empties the output.
module conic_orbit_position_core #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int PHASE_BITS        = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] delta_time
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [20:0] pos_x, [41:21] pos_y, [57:42] phase_out, rest 0
    output logic        m_tuser    // [0] saturated
);

    localparam int QB = cop_pkg::QUOT_BITS;
    localparam int RB = cop_pkg::ROT_BITS;
    localparam int AB = cop_pkg::ACC_BITS;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PHASE  = 4'd1;
    localparam logic [3:0] S_CORDIC = 4'd2;
    localparam logic [3:0] S_QUAD   = 4'd3;
    localparam logic [3:0] S_ECMUL  = 4'd4;
    localparam logic [3:0] S_DEN    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // configuration registers
    logic [15:0] semi_reg, ecc_reg;
    logic [23:0] speed_reg;
    logic [15:0] cx_reg, cy_reg;
    logic        enable_reg;
    logic [PHASE_BITS-1:0] phase_reg;

    logic [3:0]  state_reg;
    logic [5:0]  cnt_reg;          // CORDIC iteration / serial bit count
    logic [39:0] inc_reg;          // speed * dt, Q0.40
    logic [31:0] e2_reg;
    logic [QB-1:0] num_reg;        // dividend, then quotient (radius)
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic signed [RB-1:0] x_reg, y_reg, z_reg;
    logic signed [RB-1:0] c_reg, s_reg;
    logic [1:0]  quad_reg;
    logic signed [50:0] ec_reg;
    logic signed [AB-1:0] accx_reg, accy_reg;
    logic [63:0] out_data_reg;
    logic        out_sat_reg;
    logic        out_valid_reg;

    logic [31:0] phase_full;
    logic [31:0] new_phase;
    logic [PHASE_BITS-1:0] phase_sum;

    assign phase_full = 32'(phase_reg) << (32 - PHASE_BITS);
    assign phase_sum  = phase_reg + inc_reg[39:40-PHASE_BITS];
    assign new_phase  = 32'(phase_sum) << (32 - PHASE_BITS);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // CORDIC rotation step, one micro-rotation per cycle
    logic signed [RB-1:0] xs, ys, atan_ext;
    assign xs       = x_reg >>> cnt_reg[4:0];
    assign ys       = y_reg >>> cnt_reg[4:0];
    assign atan_ext = RB'(cop_pkg::atan_turns(cnt_reg[4:0]));

    // restoring division step
    logic [32:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg, num_reg[QB-1]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    // denominator from e * c
    logic signed [34:0] den_full;
    assign den_full = 35'sd1073741824 + ec_reg[50:16];

    // shift-add multiply step, radius bits LSB first
    logic signed [35:0] topx, topy, addx, addy;
    assign addx = num_reg[0] ? 36'(c_reg) : 36'sd0;
    assign addy = num_reg[0] ? 36'(s_reg) : 36'sd0;
    assign topx = accx_reg[AB-1:QB] + addx;
    assign topy = accy_reg[AB-1:QB] + addy;

    // final position and clamp
    logic signed [53:0] px, py;
    logic sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;
    logic [20:0] pos_x, pos_y;
    assign px = 54'(signed'(cx_reg)) + 54'(signed'(accx_reg[AB-1:32]));
    assign py = 54'(signed'(cy_reg)) + 54'(signed'(accy_reg[AB-1:32]));
    assign sat_x_hi = px > 54'sd1048575;
    assign sat_x_lo = px < -54'sd1048576;
    assign sat_y_hi = py > 54'sd1048575;
    assign sat_y_lo = py < -54'sd1048576;
    assign pos_x = sat_x_hi ? 21'h0FFFFF : (sat_x_lo ? 21'h100000 : px[20:0]);
    assign pos_y = sat_y_hi ? 21'h0FFFFF : (sat_y_lo ? 21'h100000 : py[20:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semi_reg      <= 16'd960;
            ecc_reg       <= '0;
            speed_reg     <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            enable_reg    <= 1'b1;
            phase_reg     <= '0;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // load a new result when the slot is free, else drain on handshake
            if (state_reg == S_OUT && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            // config only arrives while idle, if the user keeps to it; the core does not enforce it
            if (cfg_we) begin
                unique case (cfg_addr)
                    cop_pkg::REG_SEMI_MAJOR: semi_reg   <= cfg_wdata[15:0];
                    cop_pkg::REG_ECC:        ecc_reg    <= cfg_wdata[15:0];
                    cop_pkg::REG_ANG_SPEED:  speed_reg  <= cfg_wdata[23:0];
                    cop_pkg::REG_CENTER_X:   cx_reg     <= cfg_wdata[15:0];
                    cop_pkg::REG_CENTER_Y:   cy_reg     <= cfg_wdata[15:0];
                    cop_pkg::REG_ENABLE:     enable_reg <= cfg_wdata[0];
                    cop_pkg::REG_START_PH:   phase_reg  <= cfg_wdata[31:32-PHASE_BITS];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && enable_reg) begin
                        inc_reg   <= speed_reg * s_tdata;
                        state_reg <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    phase_reg <= phase_sum;
                    quad_reg  <= new_phase[31:30];
                    x_reg     <= RB'(signed'({1'b0, cop_pkg::CORDIC_X0}));
                    y_reg     <= '0;
                    z_reg     <= RB'(signed'({1'b0, new_phase[29:0]}));
                    e2_reg    <= ecc_reg * ecc_reg;
                    cnt_reg   <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (!z_reg[RB-1]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_ext;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_ext;
                    end
                    num_reg <= semi_reg * ({1'b1, 32'd0} - {1'b0, e2_reg});
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(CORDIC_ITERATIONS - 1))
                        state_reg <= S_QUAD;
                end
                S_QUAD: begin
                    case (quad_reg)
                        2'd0: begin c_reg <= x_reg;  s_reg <= y_reg;  end
                        2'd1: begin c_reg <= -y_reg; s_reg <= x_reg;  end
                        2'd2: begin c_reg <= -x_reg; s_reg <= -y_reg; end
                        default: begin c_reg <= y_reg; s_reg <= -x_reg; end
                    endcase
                    state_reg <= S_ECMUL;
                end
                S_ECMUL: begin
                    ec_reg    <= signed'({1'b0, ecc_reg}) * c_reg;
                    state_reg <= S_DEN;
                end
                S_DEN: begin
                    // guard: a non-positive denominator is forced to one
                    den_reg   <= (den_full < 35'sd1) ? 32'd1 : den_full[31:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= q_bit ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
                    num_reg <= {num_reg[QB-2:0], q_bit};
                    if (cnt_reg == 6'(QB - 1)) begin
                        cnt_reg   <= '0;
                        accx_reg  <= '0;
                        accy_reg  <= '0;
                        state_reg <= S_MUL;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_MUL: begin
                    accx_reg <= $signed({topx, accx_reg[QB-1:0]}) >>> 1;
                    accy_reg <= $signed({topy, accy_reg[QB-1:0]}) >>> 1;
                    num_reg  <= num_reg >> 1;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QB - 1))
                        state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_data_reg  <= {6'd0, phase_full[31:16], pos_y, pos_x};
                        out_sat_reg   <= sat_x_hi | sat_x_lo | sat_y_hi | sat_y_lo;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a disabled beat must not start work
    a_disabled_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !enable_reg) |=> (state_reg == S_IDLE))
        else $error("disabled beat started work");

    // divider never runs with a zero divisor
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_reg != 32'd0))
        else $error("zero denominator in divider");

    // a new result is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_valid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result overwritten while stalled");

endmodule

### test/orbit_position_checker.sv
// Watches the input and result streams of the conic orbit position core, predicts
// each position beat and compares it field by field. Depends on cop_pkg.
module orbit_position_checker #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int PHASE_BITS        = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [20:0] pos_x;
        logic [20:0] pos_y;
        logic [15:0] phase_out;
        logic        saturated;
    } orbit_pos_t;

    localparam longint signed POS_HI = 1048575;
    localparam longint signed POS_LO = -1048576;

    logic [15:0]        semi_axis;
    logic [15:0]        ecc;
    logic [23:0]        ang_speed;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               enabled;
    logic [31:0]        phase;
    orbit_pos_t         expected_positions[$];

    function automatic logic [31:0] keep_mask();
        return 32'hFFFF_FFFF << (32 - PHASE_BITS);
    endfunction

    function automatic longint signed clamp(input longint signed v, inout logic sat);
        if (v > POS_HI) begin
            sat = 1'b1;
            return POS_HI;
        end
        if (v < POS_LO) begin
            sat = 1'b1;
            return POS_LO;
        end
        return v;
    endfunction

    // advances the phase and returns the position for this time step
    function automatic orbit_pos_t advance_orbit(input logic [15:0] dt);
        longint signed x, y, z, xs, ys, c, s, den, r, px, py;
        longint unsigned e2, num;
        logic [31:0] inc;
        logic sat;
        orbit_pos_t res;
        sat = 1'b0;
        inc = 32'((64'(ang_speed) * 64'(dt)) >> 8);
        phase = (phase + inc) & keep_mask();
        x = cop_pkg::CORDIC_X0;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < CORDIC_ITERATIONS && i < cop_pkg::ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(cop_pkg::atan_turns(5'(i)));
            end else begin
                x += ys; y -= xs; z += longint'(cop_pkg::atan_turns(5'(i)));
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        e2 = 64'(ecc) * 64'(ecc);
        num = 64'(semi_axis) * ((64'd1 << 32) - e2);
        den = (longint'(1) << 30) + ((longint'(ecc) * c) >>> 16);
        if (den < 1) den = 1;
        r = longint'(num / longint'(den));
        // r*c can reach ~2^80: widen to 128 bits
        px = clamp(longint'(cx) + longint'((128'(signed'(r)) * 128'(signed'(c))) >>> 32), sat);
        py = clamp(longint'(cy) + longint'((128'(signed'(r)) * 128'(signed'(s))) >>> 32), sat);
        res.pos_x = 21'(px);
        res.pos_y = 21'(py);
        res.phase_out = phase[31:16];
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge aclk) begin
        orbit_pos_t want;
        if (!aresetn) begin
            semi_axis <= 16'd960;
            ecc <= '0;
            ang_speed <= '0;
            cx <= '0;
            cy <= '0;
            enabled <= 1'b1;
            phase <= '0;
            mismatches <= 0;
            pending <= 0;
            expected_positions.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    cop_pkg::REG_SEMI_MAJOR: semi_axis <= cfg_wdata[15:0];
                    cop_pkg::REG_ECC:        ecc <= cfg_wdata[15:0];
                    cop_pkg::REG_ANG_SPEED:  ang_speed <= cfg_wdata[23:0];
                    cop_pkg::REG_CENTER_X:   cx <= cfg_wdata[15:0];
                    cop_pkg::REG_CENTER_Y:   cy <= cfg_wdata[15:0];
                    cop_pkg::REG_ENABLE:     enabled <= cfg_wdata[0];
                    cop_pkg::REG_START_PH:   phase <= cfg_wdata & keep_mask();
                    default: ;
                endcase
            end
            // writes only happen while idle, so no beat shares a cycle with one
            if (s_tvalid && s_tready && enabled) begin
                expected_positions.insert(expected_positions.size(),
                                          advance_orbit(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_positions.size() == 0) begin
                    $error("result beat with no expectation: %h", m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_positions.pop_front();
                    if (m_tdata[20:0] !== want.pos_x ||
                        m_tdata[41:21] !== want.pos_y ||
                        m_tdata[57:42] !== want.phase_out ||
                        m_tdata[63:58] !== '0 || m_tuser !== want.saturated) begin
                        mismatches <= mismatches + 1;
                        if (m_tdata[20:0] !== want.pos_x)
                            $error("pos_x expected %h got %h", want.pos_x, m_tdata[20:0]);
                        if (m_tdata[41:21] !== want.pos_y)
                            $error("pos_y expected %h got %h", want.pos_y, m_tdata[41:21]);
                        if (m_tdata[57:42] !== want.phase_out)
                            $error("phase_out expected %h got %h", want.phase_out,
                                   m_tdata[57:42]);
                        if (m_tdata[63:58] !== '0)
                            $error("pad expected 0 got %h", m_tdata[63:58]);
                        if (m_tuser !== want.saturated)
                            $error("saturated expected %b got %b", want.saturated, m_tuser);
                    end
                end
            end
            pending <= expected_positions.size();
        end
    end
endmodule

### test/testbench.sv
// Stimulus and verdict for the conic orbit position core: register settings,
// time-step beats and random stalls. Depends on cop_pkg and orbit_position_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 200;       // longer than the core's latency
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] delta_time
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [20:0] pos_x, [41:21] pos_y, [57:42] phase_out
    logic        m_tuser;    // [0] saturated
    int          mismatches;
    int          pending;
    bit          quiet_tail;  // no stalls at the end of the run
    longint      cycles;

    conic_orbit_position_core dut (.*);
    orbit_position_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: stall in random bursts
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // waits for all results, then the core's full latency
    task automatic settle();
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one time-step beat; optional idle burst before it
    task automatic send_step(input logic [15:0] dt);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= dt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_setting();
        write_reg(cop_pkg::REG_SEMI_MAJOR,
                  $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 4000));
        write_reg(cop_pkg::REG_ECC, $urandom_range(0, 3) == 0 ? $urandom_range(60000, 65535)
                                                            : $urandom_range(0, 65535));
        write_reg(cop_pkg::REG_ANG_SPEED, $urandom & 32'hFF_FFFF);
        write_reg(cop_pkg::REG_CENTER_X, $urandom);
        write_reg(cop_pkg::REG_CENTER_Y, $urandom);
        write_reg(cop_pkg::REG_START_PH, $urandom);
        write_reg(cop_pkg::REG_ENABLE, 32'd1);
    endtask

    initial begin
        logic [15:0] dt;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet_tail = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, zero and full time steps
        send_step(16'h0000);
        send_step(16'hFFFF);
        settle();
        write_reg(cop_pkg::REG_ANG_SPEED, 32'hFF_FFFF);
        send_step(16'hFFFF);
        send_step(16'h0001);
        // each quadrant via start phase
        for (int q = 0; q < 4; q++) begin
            settle();
            write_reg(cop_pkg::REG_START_PH, {2'(q), 30'h2000_0000});
            write_reg(cop_pkg::REG_ANG_SPEED, 32'd0);
            send_step(16'h1234);
        end
        // extreme axis, eccentricity, centers: saturation both ways
        settle();
        write_reg(cop_pkg::REG_SEMI_MAJOR, 32'hFFFF);
        write_reg(cop_pkg::REG_ECC, 32'hFFFF);
        write_reg(cop_pkg::REG_CENTER_X, 32'h7FFF);
        write_reg(cop_pkg::REG_CENTER_Y, 32'h8000);
        write_reg(cop_pkg::REG_ANG_SPEED, 32'h40_0000);
        for (int k = 0; k < 6; k++) send_step(16'h4000);
        settle();
        write_reg(cop_pkg::REG_CENTER_X, 32'h8000);
        write_reg(cop_pkg::REG_CENTER_Y, 32'h7FFF);
        write_reg(cop_pkg::REG_ECC, 32'd0);
        for (int k = 0; k < 4; k++) send_step(16'h4000);
        // disabled: beats dropped, phase held
        settle();
        write_reg(cop_pkg::REG_ENABLE, 32'd0);
        send_step(16'hFFFF);
        send_step(16'h5555);
        settle();
        write_reg(cop_pkg::REG_ENABLE, 32'd1);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);   // unmapped index, ignored
        send_step(16'hAAAA);

        // random phases
        for (int ph = 0; ph < 40; ph++) begin
            settle();
            random_setting();
            if (ph == 39) quiet_tail = 1'b1;
            for (int k = 0; k < 40; k++) begin
                dt = $urandom;
                if ($urandom_range(0, 9) == 0) dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
                // brief disabled stretch inside some phases
                if (ph % 7 == 3 && k == 20) begin
                    settle();
                    write_reg(cop_pkg::REG_ENABLE, 32'd0);
                    send_step(dt);
                    settle();
                    write_reg(cop_pkg::REG_ENABLE, 32'd1);
                end
                send_step(dt);
            end
        end

        settle();
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
